// ----- rtl/core/aea_pkg.sv -----
// aea_pkg: shared sizes, codes and control types of the extent allocator
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package aea_pkg;

    // table and address sizing
    localparam int MAX_EXTENTS   = 16;
    localparam int GRANULE_BYTES = 8;
    localparam int ADDR_WIDTH    = 32;

    localparam int IDX_W     = $clog2(MAX_EXTENTS);
    localparam int END_W     = ADDR_WIDTH + 1;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 2;

    // granule remainder width and granule constant
    localparam int REM_W     = $clog2(GRANULE_BYTES + 1);
    localparam logic [REM_W:0] GRAN = (REM_W + 1)'(GRANULE_BYTES);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LOWER = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_UPPER = CFG_IDX_W'(1);

    // result codes
    typedef enum logic [STATUS_W-1:0] {
        ST_GRANT   = 2'd0,
        ST_OUTSIDE = 2'd1,
        ST_NO_FIT  = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    // operand choice of the remainder unit
    typedef enum logic {
        SEL_LOC = 1'b0,
        SEL_SUM = 1'b1
    } t_rem_sel;

    // controller to datapath
    typedef struct packed {
        logic     load;
        logic     rem_start;
        t_rem_sel rem_sel;
        logic     latch_base;
        logic     latch_size;
        logic     latch_end;
        logic     scan_clear;
        logic     scan_step;
        logic     apply;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic outside;
        logic rem_done;
        logic scan_last;
        logic out_free;
    } t_dp_sts;

endpackage

// ----- rtl/core/aea_if.sv -----
// aea_if: request and response channel interfaces of the extent allocator
// depends on aea_pkg for the address and status widths
`timescale 1ns / 1ps

interface aea_req_if;
    logic                             valid;
    logic                             ready;
    logic [aea_pkg::ADDR_WIDTH-1:0]   location;
    logic [aea_pkg::ADDR_WIDTH-1:0]   byte_size;

    modport source (output valid, output location, output byte_size, input ready);
    modport sink   (input valid, input location, input byte_size, output ready);
endinterface

interface aea_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [aea_pkg::STATUS_W-1:0]     status;
    logic [aea_pkg::ADDR_WIDTH-1:0]   granted_address;
    logic [aea_pkg::ADDR_WIDTH-1:0]   granted_size;
    logic [aea_pkg::ADDR_WIDTH-1:0]   free_after;

    modport source (output valid, output status, output granted_address,
                    output granted_size, output free_after, input ready);
    modport sink   (input valid, input status, input granted_address,
                    input granted_size, input free_after, output ready);
endinterface

// ----- rtl/core/aea_rem_unit.sv -----
// aea_rem_unit: unsigned remainder by the granule, registered the cycle after start
// depends on aea_pkg for widths and the granule constant
`timescale 1ns / 1ps

module aea_rem_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [aea_pkg::END_W-1:0]   i_operand,
    output logic                        o_done,
    output logic [aea_pkg::REM_W-1:0]   o_rem
);
    import aea_pkg::*;

    logic [REM_W-1:0]    r_rem;
    logic                r_done;

    // low operand bits below the granule, held until the next start
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
            r_rem  <= '0;
        end else begin
            r_done <= i_start;
            if (i_start) begin
                r_rem <= REM_W'(i_operand % GRANULE_BYTES);
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ----- rtl/core/aea_datapath.sv -----
// aea_datapath: region registers, extent table, alignment, scan and result register
// depends on aea_pkg and aea_rem_unit
`timescale 1ns / 1ps

module aea_datapath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  aea_pkg::t_dp_cmd               i_cmd,
    output aea_pkg::t_dp_sts               o_sts,
    input  logic [aea_pkg::ADDR_WIDTH-1:0] i_location,
    input  logic [aea_pkg::ADDR_WIDTH-1:0] i_byte_size,
    input  logic                           i_cfg_we,
    input  logic [aea_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [aea_pkg::ADDR_WIDTH-1:0] i_cfg_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [aea_pkg::STATUS_W-1:0]   o_status,
    output logic [aea_pkg::ADDR_WIDTH-1:0] o_granted_address,
    output logic [aea_pkg::ADDR_WIDTH-1:0] o_granted_size,
    output logic [aea_pkg::ADDR_WIDTH-1:0] o_free_after
);
    import aea_pkg::*;

    // region and table state
    logic [ADDR_WIDTH-1:0] r_lower;
    logic [ADDR_WIDTH-1:0] r_upper;
    logic [ADDR_WIDTH-1:0] r_free;
    logic [ADDR_WIDTH-1:0] r_ext_start [MAX_EXTENTS];
    logic [END_W-1:0]      r_ext_end   [MAX_EXTENTS];
    logic [MAX_EXTENTS-1:0] r_ext_valid;

    // per request working registers
    logic [ADDR_WIDTH-1:0] r_loc;
    logic [ADDR_WIDTH-1:0] r_req;
    logic                  r_outside;
    logic [ADDR_WIDTH-1:0] r_base;
    logic [END_W-1:0]      r_sum;
    logic [END_W-1:0]      r_size;
    logic [END_W-1:0]      r_end;

    // scan registers
    logic [IDX_W-1:0]      r_idx;
    logic                  r_hit_found;
    logic [IDX_W-1:0]      r_hit_idx;
    logic [ADDR_WIDTH-1:0] r_hit_s;
    logic [END_W-1:0]      r_hit_e;
    logic                  r_spare_found;
    logic [IDX_W-1:0]      r_spare_idx;

    // result register
    logic                  r_out_valid;
    t_status               r_out_status;
    logic [ADDR_WIDTH-1:0] r_out_addr;
    logic [ADDR_WIDTH-1:0] r_out_size;
    logic [ADDR_WIDTH-1:0] r_out_free;

    logic                  w_rem_done;
    logic [REM_W-1:0]      w_rem;
    logic [END_W-1:0]      w_rem_operand;
    logic [END_W-1:0]      w_sum_now;
    logic [REM_W:0]        w_pad;

    logic                  w_cfg_hit;
    logic [ADDR_WIDTH-1:0] n_lower;
    logic [ADDR_WIDTH-1:0] n_upper;
    logic [ADDR_WIDTH-1:0] w_region_sz;
    logic [END_W-1:0]      w_region_end;

    logic                  w_rd_valid;
    logic [ADDR_WIDTH-1:0] w_rd_start;
    logic [END_W-1:0]      w_rd_end;
    logic                  w_holds;

    logic                  w_head;
    logic                  w_tail;
    t_status               w_status;
    logic                  w_grant;
    logic [ADDR_WIDTH-1:0] w_free_new;
    logic                  w_out_free;

    // remainder by the granule, shared by the start offset and the size round-up
    assign w_sum_now     = {1'b0, r_req} + END_W'(w_rem);
    assign w_rem_operand = (i_cmd.rem_sel == SEL_SUM) ? w_sum_now : {1'b0, r_loc};

    aea_rem_unit u_rem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_cmd.rem_start),
        .i_operand (w_rem_operand),
        .o_done    (w_rem_done),
        .o_rem     (w_rem)
    );

    assign w_pad = (w_rem == '0) ? '0 : (GRAN - {1'b0, w_rem});

    // region rebuild on a register write
    assign w_cfg_hit    = i_cfg_we && (i_cfg_idx == REG_LOWER || i_cfg_idx == REG_UPPER);
    assign n_lower      = (i_cfg_we && i_cfg_idx == REG_LOWER) ? i_cfg_data : r_lower;
    assign n_upper      = (i_cfg_we && i_cfg_idx == REG_UPPER) ? i_cfg_data : r_upper;
    assign w_region_sz  = (n_upper > n_lower) ? (n_upper - n_lower) : '0;
    assign w_region_end = {1'b0, n_lower} + {1'b0, w_region_sz};

    // one table entry examined per scan cycle
    assign w_rd_valid = r_ext_valid[r_idx];
    assign w_rd_start = r_ext_start[r_idx];
    assign w_rd_end   = r_ext_end[r_idx];
    assign w_holds    = (w_rd_end >= r_end) && (w_rd_start <= r_base)
                        && (!r_hit_found || w_rd_start < r_hit_s);

    // outcome of the scan
    assign w_head = (r_hit_s != r_base);
    assign w_tail = (r_hit_e != r_end);

    always_comb begin
        if (r_outside) begin
            w_status = ST_OUTSIDE;
        end else if (!r_hit_found) begin
            w_status = ST_NO_FIT;
        end else if (w_head && w_tail && !r_spare_found) begin
            w_status = ST_FULL;
        end else begin
            w_status = ST_GRANT;
        end
    end

    assign w_grant    = (w_status == ST_GRANT);
    assign w_free_new = r_free - r_size[ADDR_WIDTH-1:0];
    assign w_out_free = !r_out_valid || i_out_ready;

    // region registers, extent table and free byte count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower        <= '0;
            r_upper        <= '0;
            r_free         <= '0;
            r_ext_valid    <= MAX_EXTENTS'(1);
            r_ext_start[0] <= '0;
            r_ext_end[0]   <= '0;
        end else if (w_cfg_hit) begin
            r_lower        <= n_lower;
            r_upper        <= n_upper;
            r_free         <= w_region_sz;
            r_ext_valid    <= MAX_EXTENTS'(1);
            r_ext_start[0] <= n_lower;
            r_ext_end[0]   <= w_region_end;
        end else if (i_cmd.apply && w_grant) begin
            r_free <= w_free_new;
            if (w_head) begin
                r_ext_end[r_hit_idx] <= {1'b0, r_base};
                if (w_tail) begin
                    r_ext_start[r_spare_idx] <= r_end[ADDR_WIDTH-1:0];
                    r_ext_end[r_spare_idx]   <= r_hit_e;
                    r_ext_valid[r_spare_idx] <= 1'b1;
                end
            end else if (w_tail) begin
                r_ext_start[r_hit_idx] <= r_end[ADDR_WIDTH-1:0];
            end else begin
                r_ext_valid[r_hit_idx] <= 1'b0;
            end
        end
    end

    // request capture and alignment
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_loc     <= i_location;
            r_req     <= i_byte_size;
            r_outside <= (i_location < r_lower)
                         || (({1'b0, i_location} + {1'b0, i_byte_size}) > {1'b0, r_upper});
        end
        if (i_cmd.latch_base) begin
            r_base <= r_loc - ADDR_WIDTH'(w_rem);
            r_sum  <= w_sum_now;
        end
        if (i_cmd.latch_size) begin
            r_size <= r_sum + END_W'(w_pad);
        end
        if (i_cmd.latch_end) begin
            r_end <= {1'b0, r_base} + r_size;
        end
    end

    // scan over the table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx         <= '0;
            r_hit_found   <= 1'b0;
            r_spare_found <= 1'b0;
        end else if (i_cmd.scan_clear) begin
            r_idx         <= '0;
            r_hit_found   <= 1'b0;
            r_spare_found <= 1'b0;
        end else if (i_cmd.scan_step) begin
            r_idx <= r_idx + IDX_W'(1);
            if (!w_rd_valid) begin
                if (!r_spare_found) begin
                    r_spare_found <= 1'b1;
                    r_spare_idx   <= r_idx;
                end
            end else if (w_holds) begin
                r_hit_found <= 1'b1;
                r_hit_idx   <= r_idx;
                r_hit_s     <= w_rd_start;
                r_hit_e     <= w_rd_end;
            end
        end
    end

    // result register, freed when the beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.apply) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.apply) begin
            r_out_status <= w_status;
            r_out_addr   <= w_grant ? r_base : '0;
            r_out_size   <= w_grant ? r_size[ADDR_WIDTH-1:0] : '0;
            r_out_free   <= w_grant ? w_free_new : r_free;
        end
    end

    assign o_sts.outside   = r_outside;
    assign o_sts.rem_done  = w_rem_done;
    assign o_sts.scan_last = (r_idx == IDX_W'(MAX_EXTENTS - 1));
    assign o_sts.out_free  = w_out_free;

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_out_status;
    assign o_granted_address = r_out_addr;
    assign o_granted_size    = r_out_size;
    assign o_free_after      = r_out_free;

endmodule

// ----- rtl/core/aea_ctrl.sv -----
// aea_ctrl: sequencer of one request through align, scan and update
// depends on aea_pkg for the command and status types
`timescale 1ns / 1ps

module aea_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output aea_pkg::t_dp_cmd o_cmd,
    input  aea_pkg::t_dp_sts i_sts
);
    import aea_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_REM_LOC,
        S_REM_SUM,
        S_END,
        S_SCAN,
        S_UPDATE
    } t_state;

    t_state r_state;
    t_state n_state;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.outside) begin
                    n_state = S_UPDATE;
                end else begin
                    o_cmd.rem_start = 1'b1;
                    o_cmd.rem_sel   = SEL_LOC;
                    n_state         = S_REM_LOC;
                end
            end
            S_REM_LOC: begin
                if (i_sts.rem_done) begin
                    o_cmd.latch_base = 1'b1;
                    o_cmd.rem_start  = 1'b1;
                    o_cmd.rem_sel    = SEL_SUM;
                    n_state          = S_REM_SUM;
                end
            end
            S_REM_SUM: begin
                if (i_sts.rem_done) begin
                    o_cmd.latch_size = 1'b1;
                    n_state          = S_END;
                end
            end
            S_END: begin
                o_cmd.latch_end  = 1'b1;
                o_cmd.scan_clear = 1'b1;
                n_state          = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                if (i_sts.out_free) begin
                    o_cmd.apply = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

// ----- rtl/core/absolute_extent_allocator.sv -----
// absolute_extent_allocator: top level, claims fixed address ranges from a free extent table
// depends on aea_pkg, aea_if, aea_ctrl and aea_datapath
//
// Usage: a request beat on i_req carries location and byte_size. It is checked
// against the region [region_lower, region_upper), aligned to the granule and
// cut out of the free extent that holds it. Exactly one response beat on o_rsp
// follows each request: status, granted_address, granted_size, free_after.
// Writing region register 0 or 1 through i_cfg_* rebuilds the table as a single
// extent covering the region; the user must keep writes to times when no request is
// in flight, since the block does not enforce this. One request is worked at a time.
// A request inside the region passes the check, two remainder states and an end
// state to be checked and aligned, one table entry per scan cycle, and the update,
// which loads its response beat into the output register. A request outside the
// region goes from the check straight to the update; both return to idle after it.
// The response sits in an output register; the next request is accepted while
// it waits, and the sequencer holds before its update until that beat is taken.
// Reset (synchronous, active low) clears both region registers, so the table
// holds one empty extent at address 0 and free_after reads 0.
`timescale 1ns / 1ps

module absolute_extent_allocator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    aea_req_if.sink                        i_req,
    aea_rsp_if.source                      o_rsp,
    input  logic                           i_cfg_we,
    input  logic [aea_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [aea_pkg::ADDR_WIDTH-1:0] i_cfg_data
);
    import aea_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // sequencer
    aea_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    // table, alignment and result register
    aea_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_location        (i_req.location),
        .i_byte_size       (i_req.byte_size),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .o_out_valid       (o_rsp.valid),
        .i_out_ready       (o_rsp.ready),
        .o_status          (o_rsp.status),
        .o_granted_address (o_rsp.granted_address),
        .o_granted_size    (o_rsp.granted_size),
        .o_free_after      (o_rsp.free_after)
    );

endmodule

// ----- rtl/core/aea_checker.sv -----
// aea_checker: port level assertions for the extent allocator, bound to the top level
// depends on aea_pkg for widths and result codes
`timescale 1ns / 1ps

module aea_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_req_valid,
    input logic                           i_req_ready,
    input logic                           i_rsp_valid,
    input logic                           i_rsp_ready,
    input logic [aea_pkg::STATUS_W-1:0]   i_rsp_status,
    input logic [aea_pkg::ADDR_WIDTH-1:0] i_rsp_addr,
    input logic [aea_pkg::ADDR_WIDTH-1:0] i_rsp_size,
    input logic [aea_pkg::ADDR_WIDTH-1:0] i_rsp_free
);
    import aea_pkg::*;

    // no response beat right out of reset
    a_no_rsp_after_reset: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !i_rsp_valid
    ) else $error("response valid right after reset");

    // refused requests carry no range
    a_refused_zero: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_rsp_status != ST_GRANT) |-> (i_rsp_addr == '0 && i_rsp_size == '0)
    ) else $error("refused response with nonzero address or size");

    // one request in flight: ready drops after each accepted beat
    a_one_in_flight: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready
    ) else $error("request accepted while another is in flight");

    // stalled response beat holds
    a_rsp_hold: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=> (i_rsp_valid && $stable(i_rsp_status)
            && $stable(i_rsp_addr) && $stable(i_rsp_size) && $stable(i_rsp_free))
    ) else $error("stalled response changed");

endmodule

bind absolute_extent_allocator aea_checker u_aea_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_status (o_rsp.status),
    .i_rsp_addr   (o_rsp.granted_address),
    .i_rsp_size   (o_rsp.granted_size),
    .i_rsp_free   (o_rsp.free_after)
);

// ----- dv/tb_absolute_extent_allocator.sv -----
// tb_absolute_extent_allocator: self-checking bench for the absolute extent allocator
// depends on aea_pkg, aea_if and the absolute_extent_allocator rtl; predicts every
// response beat from its own copy of the extent table and compares field by field
`timescale 1ns / 1ps

module tb_absolute_extent_allocator;
    import aea_pkg::*;

    localparam int AW              = ADDR_WIDTH;
    localparam int STUCK_LIMIT     = 4000;
    localparam int RX_HOLD         = 400;
    localparam int SETTLE_CYCLES   = 4;
    localparam int TAIL_CYCLES     = 60;
    localparam int NUM_PHASES      = 25;
    localparam int ITEMS_PER_PHASE = 49;
    localparam int PRESSURE_PHASE  = 20;

    // register indexes that decode to nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

    typedef struct {
        t_status         status;
        logic [AW-1:0]   address;
        logic [AW-1:0]   size;
        logic [AW-1:0]   free_after;
    } t_grant;

    // free extent table mirror and queue of responses still owed
    class extent_book;
        logic [AW-1:0] lower;
        logic [AW-1:0] upper;
        logic [AW-1:0] ext_base [MAX_EXTENTS];
        logic [AW-1:0] ext_len  [MAX_EXTENTS];
        bit            ext_live [MAX_EXTENTS];
        logic [AW-1:0] free_bytes;
        t_grant        awaited [$];
        int            mismatches;
        int            requests;
        int            status_count [4];

        // whole region becomes one extent
        function void rebuild();
            int i;
            logic [AW-1:0] span;
            span = (upper > lower) ? upper - lower : '0;
            for (i = 0; i < MAX_EXTENTS; i++) begin
                ext_base[i] = '0;
                ext_len[i]  = '0;
                ext_live[i] = 1'b0;
            end
            ext_base[0] = lower;
            ext_len[0]  = span;
            ext_live[0] = 1'b1;
            free_bytes  = span;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [AW-1:0] value);
            if (idx == REG_LOWER) begin
                lower = value;
                rebuild();
            end else if (idx == REG_UPPER) begin
                upper = value;
                rebuild();
            end
        endfunction

        // accepted request beat: cut the range out of the table, owe one response
        function void claim(logic [AW-1:0] loc, logic [AW-1:0] req);
            t_grant     g;
            bit [63:0]  gran, off, base, len, fin, s, e;
            int         hit, spare, i;
            bit         head, tail;
            g.status     = ST_GRANT;
            g.address    = '0;
            g.size       = '0;
            hit          = -1;
            spare        = -1;
            gran         = 64'(GRANULE_BYTES);
            requests++;
            if (loc < lower || 64'(loc) + 64'(req) > 64'(upper)) begin
                g.status = ST_OUTSIDE;
            end else begin
                off  = 64'(loc) % gran;
                base = 64'(loc) - off;
                len  = ((64'(req) + off + gran - 1) / gran) * gran;
                fin  = base + len;
                // lowest-start valid extent that holds the aligned range
                for (i = 0; i < MAX_EXTENTS; i++) begin
                    if (!ext_live[i]) begin
                        if (spare < 0) spare = i;
                    end else begin
                        s = 64'(ext_base[i]);
                        e = s + 64'(ext_len[i]);
                        if (e >= fin && s <= base) begin
                            if (hit < 0 || ext_base[i] < ext_base[hit]) hit = i;
                        end
                    end
                end
                if (hit < 0) begin
                    g.status = ST_NO_FIT;
                end else begin
                    s    = 64'(ext_base[hit]);
                    e    = s + 64'(ext_len[hit]);
                    tail = (e != fin);
                    head = (s != base);
                    if (tail && head && spare < 0) begin
                        g.status = ST_FULL;
                    end else begin
                        if (head) begin
                            ext_len[hit] = AW'(base - s);
                            if (tail) begin
                                ext_base[spare] = AW'(fin);
                                ext_len[spare]  = AW'(e - fin);
                                ext_live[spare] = 1'b1;
                            end
                        end else if (tail) begin
                            ext_base[hit] = AW'(fin);
                            ext_len[hit]  = AW'(e - fin);
                        end else begin
                            ext_live[hit] = 1'b0;
                            ext_base[hit] = '0;
                            ext_len[hit]  = '0;
                        end
                        free_bytes = free_bytes - AW'(len);
                        g.address  = AW'(base);
                        g.size     = AW'(len);
                    end
                end
            end
            g.free_after = free_bytes;
            awaited.push_back(g);
        endfunction

        function void compare_field(string field, logic [AW-1:0] want, logic [AW-1:0] got);
            if (got !== want) begin
                $display("%0t mismatch in %s: expected %h, actual %h", $time, field, want, got);
                mismatches++;
            end
        endfunction

        // response beat taken: compare with the oldest owed response
        function void match_response(logic [STATUS_W-1:0] st, logic [AW-1:0] addr,
                                     logic [AW-1:0] size, logic [AW-1:0] free_after);
            t_grant g;
            if (awaited.size() == 0) begin
                $display("%0t mismatch: response beat with nothing owed, status %0d addr %h",
                         $time, st, addr);
                mismatches++;
                return;
            end
            g = awaited.pop_front();
            status_count[g.status]++;
            compare_field("status", AW'(g.status), AW'(st));
            compare_field("granted_address", g.address, addr);
            compare_field("granted_size", g.size, size);
            compare_field("free_after", g.free_after, free_after);
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [AW-1:0]        cfg_data;

    aea_req_if req_ch ();
    aea_rsp_if rsp_ch ();

    extent_book book = new;

    int send_idle_pct;
    int recv_idle_pct;
    int hold_serial;
    int stuck_cycles;
    int region_settings;

    absolute_extent_allocator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // response side: random ready, one long hold-off on request, check each beat
    initial begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
                book.match_response(rsp_ch.status, rsp_ch.granted_address,
                                    rsp_ch.granted_size, rsp_ch.free_after);
            end
            if (hold_serial != hold_seen) begin
                hold_seen = hold_serial;
                hold_left = RX_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // watchdog: cycles with no beat on either channel and no register write
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || cfg_we ||
            !i_rst_n) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("%0t watchdog: no beat for %0d cycles", $time, stuck_cycles);
            $display("Mismatches found");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // one request beat, with random gaps ahead of it
    task automatic send_request(input logic [AW-1:0] loc, input logic [AW-1:0] len);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.location  <= loc;
        req_ch.byte_size <= len;
        @(posedge i_clk);
        while (req_ch.ready !== 1'b1) @(posedge i_clk);
        book.claim(loc, len);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [AW-1:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge i_clk);
        book.write_reg(idx, value);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_region(input logic [AW-1:0] lo, input logic [AW-1:0] hi,
                              input bit upper_first);
        if (upper_first) begin
            write_reg(REG_UPPER, hi);
            write_reg(REG_LOWER, lo);
        end else begin
            write_reg(REG_LOWER, lo);
            write_reg(REG_UPPER, hi);
        end
        region_settings++;
    endtask

    // stop offering and wait until every owed response has been taken
    task automatic drain();
        req_ch.valid <= 1'b0;
        while (book.awaited.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // mostly small requests inside the region, some noise and boundary cases
    function automatic void pick_request(output logic [AW-1:0] loc, output logic [AW-1:0] len);
        logic [AW-1:0] lo, hi;
        bit [63:0]     span;
        int            kind;
        lo   = book.lower;
        hi   = book.upper;
        span = (hi > lo) ? 64'(hi - lo) : 64'd0;
        kind = $urandom_range(99);
        if (kind < 70 && span != 0) begin
            loc = lo + AW'({$urandom, $urandom} % span);
            if ($urandom_range(3) == 0) loc[2:0] = '0;
            case ($urandom_range(9))
                0:             len = '0;
                1, 2, 3, 4, 5: len = $urandom_range(24, 1);
                6, 7, 8:       len = $urandom_range(128, 1);
                default:       len = AW'({$urandom, $urandom} % (span + 1));
            endcase
        end else if (kind < 85) begin
            loc = $urandom;
            len = $urandom >> $urandom_range(31);
        end else begin
            case ($urandom_range(4))
                0: begin
                    loc = hi - $urandom_range(16);
                    len = $urandom_range(16);
                end
                1: begin
                    loc = lo;
                    len = '1;
                end
                2: begin
                    loc = '1 - $urandom_range(8);
                    len = $urandom_range(8);
                end
                3: begin
                    loc = lo + $urandom_range(15);
                    len = '0;
                end
                default: begin
                    loc = lo;
                    len = hi - lo;
                end
            endcase
        end
    endfunction

    // stimulus
    initial begin
        logic [AW-1:0] lo, hi, loc, len;
        int            p, k;
        send_idle_pct   = 21;
        recv_idle_pct   = 58;
        hold_serial     = 0;
        region_settings = 0;
        i_rst_n          <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_idx          <= REG_LOWER;
        cfg_data         <= '0;
        req_ch.valid     <= 1'b0;
        req_ch.location  <= '0;
        req_ch.byte_size <= '0;
        book.rebuild();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty region at zero after reset: a zero-size claim empties the table
        send_request('0, '0);
        send_request('0, '0);
        drain();

        // full address space
        set_region('0, '1, 1'b0);
        send_request(32'hFFFF_FFF0, 32'h10);
        send_request('0, '1);
        send_request(32'h13, 32'h5);
        send_request(32'h40, '0);
        send_request(32'h40, '0);
        send_request('1, '1);
        drain();

        // writes to undecoded indexes leave the table alone
        write_reg(REG_SPARE_A, 32'h0000_1234);
        write_reg(REG_SPARE_B, '1);

        // inverted region
        set_region(32'h2000, 32'h1000, 1'b0);
        send_request(32'h2000, '0);
        drain();

        // lower bound off the granule
        set_region(32'h1003, 32'h1100, 1'b1);
        send_request(32'h1003, 32'h4);
        send_request(32'h1008, 32'h8);
        drain();

        // repeated splits until no table entry is left
        set_region(32'h100, 32'h300, 1'b0);
        for (k = 0; k < MAX_EXTENTS; k++) send_request(32'h108 + 16 * k, 32'h8);
        drain();

        // random phases, each with its own region
        for (p = 0; p < NUM_PHASES; p++) begin
            if (p < NUM_PHASES / 3) begin
                send_idle_pct = 21;
                recv_idle_pct = 58;
            end else if (p < 2 * NUM_PHASES / 3) begin
                send_idle_pct = 58;
                recv_idle_pct = 21;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (p % 6)
                0, 1, 2: begin
                    lo = $urandom_range(32'hFFFF_0000) & ~AW'(7);
                    hi = lo + ($urandom_range(1024, 64) & ~AW'(7));
                end
                3: begin
                    lo = ($urandom_range(32'hFFFF_0000) & ~AW'(7)) | $urandom_range(7, 1);
                    hi = lo + $urandom_range(512, 16);
                end
                4: begin
                    lo = $urandom;
                    hi = $urandom;
                end
                default: begin
                    case ($urandom_range(2))
                        0: begin
                            lo = '0;
                            hi = '1;
                        end
                        1: begin
                            lo = 32'hFFFF_FF00;
                            hi = '1;
                        end
                        default: begin
                            lo = $urandom & ~AW'(7);
                            hi = lo;
                        end
                    endcase
                end
            endcase
            set_region(lo, hi, $urandom_range(1));
            if ($urandom_range(3) == 0) begin
                write_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, $urandom);
            end
            for (k = 0; k < ITEMS_PER_PHASE; k++) begin
                // long response stall while requests keep coming
                if (p == PRESSURE_PHASE && k == 3) hold_serial++;
                pick_request(loc, len);
                send_request(loc, len);
            end
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (book.awaited.size() != 0) begin
            $display("%0t mismatch: %0d responses never arrived", $time, book.awaited.size());
            book.mismatches += book.awaited.size();
        end
        $display("covered %0d requests over %0d region settings", book.requests,
                 region_settings);
        $display("granted %0d, outside %0d, no fit %0d, table full %0d",
                 book.status_count[ST_GRANT], book.status_count[ST_OUTSIDE],
                 book.status_count[ST_NO_FIT], book.status_count[ST_FULL]);
        if (book.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
